[hdl/gcode_line_classifier_defines.svh]
// ----------------------------------------------------------------------------
// gcode_line_classifier_defines
// Assertion macros used by the classifier top level to check itself.
// ----------------------------------------------------------------------------
`ifndef GCODE_LINE_CLASSIFIER_DEFINES_SVH
`define GCODE_LINE_CLASSIFIER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GCL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gcl check failed");

// next-cycle implication, disabled during reset
`define GCL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gcl check failed");

`endif

[hdl/gcl_pkg.sv]
// ----------------------------------------------------------------------------
// gcl_pkg
// Types, constants and the class lookup of the G-code line classifier.
// ----------------------------------------------------------------------------
package gcl_pkg;

    localparam int GCL_QUEUE_DEPTH = 4;
    localparam int GCL_VALUE_W     = 10;
    localparam int GCL_SUM_W       = 14;
    localparam logic [GCL_VALUE_W-1:0] GCL_VALUE_MAX = 10'd1023;

    typedef enum logic [3:0] {
        K_OTHER,
        K_NUL,
        K_EOL,
        K_MARK,
        K_BLANK,
        K_G,
        K_M,
        K_PLUS,
        K_MINUS,
        K_DIGIT
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  digit;
        logic        last;
    } t_token;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

    typedef enum logic [3:0] {
        CL_NONE,
        CL_MOVE,
        CL_DWELL,
        CL_RETRACT,
        CL_INCH,
        CL_MM,
        CL_ABS,
        CL_REL,
        CL_EABS,
        CL_EREL,
        CL_MAXFEED,
        CL_ACCEL,
        CL_JDEV,
        CL_RLEN,
        CL_PLEN,
        CL_SPEEDOVER
    } t_class;

    function automatic t_class class_of(input logic is_m, input logic neg,
                                        input logic [GCL_VALUE_W-1:0] v);
        t_class c;
        c = CL_NONE;
        if (!(neg && (v != '0))) begin
            if (!is_m) begin
                case (v)
                    10'd0, 10'd1:   c = CL_MOVE;
                    10'd4:          c = CL_DWELL;
                    10'd10, 10'd11: c = CL_RETRACT;
                    10'd20:         c = CL_INCH;
                    10'd21:         c = CL_MM;
                    10'd90:         c = CL_ABS;
                    10'd91:         c = CL_REL;
                    default:        c = CL_NONE;
                endcase
            end else begin
                case (v)
                    10'd82:  c = CL_EABS;
                    10'd83:  c = CL_EREL;
                    10'd203: c = CL_MAXFEED;
                    10'd204: c = CL_ACCEL;
                    10'd205: c = CL_JDEV;
                    10'd207: c = CL_RLEN;
                    10'd208: c = CL_PLEN;
                    10'd220: c = CL_SPEEDOVER;
                    default: c = CL_NONE;
                endcase
            end
        end
        return c;
    endfunction

endpackage

[hdl/gcl_front.sv]
// ----------------------------------------------------------------------------
// gcl_front
// Accepts input beats and sorts each byte into a token kind for the queue.
// ----------------------------------------------------------------------------
module gcl_front (
    input  logic           i_valid,
    input  logic [7:0]     i_line_byte,
    input  logic           i_last_byte,
    output logic           o_ready,
    input  gcl_pkg::t_q_stat i_q_stat,
    output logic           o_push,
    output gcl_pkg::t_token  o_token
);
    import gcl_pkg::*;

    t_kind kind;

    always_comb begin
        case (i_line_byte)
            8'h00:                      kind = K_NUL;
            8'h0A, 8'h0D:               kind = K_EOL;
            8'h3B, 8'h23:               kind = K_MARK;
            8'h20, 8'h09, 8'h0B, 8'h0C: kind = K_BLANK;
            8'h47, 8'h67:               kind = K_G;
            8'h4D, 8'h6D:               kind = K_M;
            8'h2B:                      kind = K_PLUS;
            8'h2D:                      kind = K_MINUS;
            default: begin
                if (i_line_byte >= 8'h30 && i_line_byte <= 8'h39) begin
                    kind = K_DIGIT;
                end else begin
                    kind = K_OTHER;
                end
            end
        endcase
    end

    assign o_ready       = !i_q_stat.full;
    assign o_push        = i_valid && !i_q_stat.full;
    assign o_token.kind  = kind;
    assign o_token.digit = i_line_byte[3:0];
    assign o_token.last  = i_last_byte;

endmodule

[hdl/gcl_queue.sv]
// ----------------------------------------------------------------------------
// gcl_queue
// Short token queue between the classifying front and the parsing back.
// ----------------------------------------------------------------------------
module gcl_queue #(
    parameter int QUEUE_DEPTH = gcl_pkg::GCL_QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  gcl_pkg::t_token                i_token,
    input  logic                           i_pop,
    output gcl_pkg::t_token                o_token,
    output gcl_pkg::t_q_stat               o_stat,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_count
);
    import gcl_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_token        r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_token;
        end
    end

    assign o_token          = r_mem[r_rd];
    assign o_stat.full      = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.not_empty = (r_count != '0);
    assign o_count          = r_count;

endmodule

[hdl/gcl_back.sv]
// ----------------------------------------------------------------------------
// gcl_back
// Walks the token stream of a line and registers its command class.
// ----------------------------------------------------------------------------
module gcl_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gcl_pkg::t_token  i_token,
    input  gcl_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [3:0]       o_command_class
);
    import gcl_pkg::*;

    typedef enum logic [2:0] {
        PH_SCAN,
        PH_WS,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    t_phase                 r_phase;
    logic                   r_is_m;
    logic                   r_neg;
    logic [GCL_VALUE_W-1:0] r_value;
    t_class                 r_decided;
    logic                   r_out_valid;
    t_class                 r_out_class;

    t_phase                 n_phase;
    logic                   n_is_m;
    logic                   n_neg;
    logic [GCL_VALUE_W-1:0] n_value;
    t_class                 n_decided;
    t_class                 line_class;
    logic [GCL_SUM_W-1:0]   sum;
    logic [GCL_VALUE_W-1:0] sat_value;
    logic                   can_load;

    assign sum = GCL_SUM_W'(r_value) * GCL_SUM_W'(10)
               + GCL_SUM_W'(i_token.digit);
    assign sat_value = (sum > GCL_SUM_W'(GCL_VALUE_MAX)) ? GCL_VALUE_MAX
                                                         : sum[GCL_VALUE_W-1:0];

    always_comb begin
        n_phase   = r_phase;
        n_is_m    = r_is_m;
        n_neg     = r_neg;
        n_value   = r_value;
        n_decided = r_decided;
        case (r_phase)
            PH_SCAN: begin
                case (i_token.kind)
                    K_NUL, K_EOL, K_MARK: begin
                        n_decided = CL_NONE;
                        n_phase   = PH_DONE;
                    end
                    K_G: begin
                        n_is_m  = 1'b0;
                        n_phase = PH_WS;
                    end
                    K_M: begin
                        n_is_m  = 1'b1;
                        n_phase = PH_WS;
                    end
                    default: ;
                endcase
            end
            PH_WS: begin
                case (i_token.kind)
                    K_BLANK, K_EOL: ;
                    K_PLUS, K_MINUS: begin
                        n_neg   = (i_token.kind == K_MINUS);
                        n_phase = PH_SIGN;
                    end
                    K_DIGIT: begin
                        n_value = sat_value;
                        n_phase = PH_DIGITS;
                    end
                    default: begin
                        n_decided = class_of(r_is_m, r_neg, r_value);
                        n_phase   = PH_DONE;
                    end
                endcase
            end
            PH_SIGN, PH_DIGITS: begin
                if (i_token.kind == K_DIGIT) begin
                    n_value = sat_value;
                    n_phase = PH_DIGITS;
                end else begin
                    n_decided = class_of(r_is_m, r_neg, r_value);
                    n_phase   = PH_DONE;
                end
            end
            default: n_phase = PH_DONE;
        endcase
    end

    always_comb begin
        case (n_phase)
            PH_DONE: line_class = n_decided;
            PH_SCAN: line_class = CL_NONE;
            default: line_class = class_of(n_is_m, n_neg, n_value);
        endcase
    end

    assign can_load = !r_out_valid || i_ready;
    assign o_pop    = i_q_stat.not_empty && (!i_token.last || can_load);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SCAN;
            r_is_m      <= 1'b0;
            r_neg       <= 1'b0;
            r_value     <= '0;
            r_decided   <= CL_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_token.last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_token.last) begin
                    r_phase     <= PH_SCAN;
                    r_is_m      <= 1'b0;
                    r_neg       <= 1'b0;
                    r_value     <= '0;
                    r_decided   <= CL_NONE;
                    r_out_class <= line_class;
                end else begin
                    r_phase   <= n_phase;
                    r_is_m    <= n_is_m;
                    r_neg     <= n_neg;
                    r_value   <= n_value;
                    r_decided <= n_decided;
                end
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_command_class = r_out_class;

endmodule

[hdl/gcode_line_classifier.sv]
// ----------------------------------------------------------------------------
// gcode_line_classifier
// Classifies a G-code line, one byte per beat, into a command class.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   line    | in        | i_valid / o_ready  | i_line_byte, i_last_byte
//   class   | out       | o_valid / i_ready  | o_command_class
//
// One byte per cycle is taken while the queue is not full. The last byte
// of a line is first written into the queue, and its class is registered
// in the back part at the edge where that byte leaves the queue; o_valid
// rises only after both.
// Reset is synchronous; no clearing pass, the block is ready right after.
// A stalled class output holds only the last byte of the next line; the
// queue keeps taking bytes until it holds QUEUE_DEPTH of them.
// ----------------------------------------------------------------------------
`include "gcode_line_classifier_defines.svh"

module gcode_line_classifier #(
    parameter int QUEUE_DEPTH = gcl_pkg::GCL_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_line_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_command_class
);
    import gcl_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          q_push;
    logic          q_pop;
    t_token        front_token;
    t_token        q_token;
    t_q_stat       q_stat;
    logic [CW-1:0] q_count;

    gcl_front u_front (
        .i_valid     (i_valid),
        .i_line_byte (i_line_byte),
        .i_last_byte (i_last_byte),
        .o_ready     (o_ready),
        .i_q_stat    (q_stat),
        .o_push      (q_push),
        .o_token     (front_token)
    );

    gcl_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_token (front_token),
        .i_pop   (q_pop),
        .o_token (q_token),
        .o_stat  (q_stat),
        .o_count (q_count)
    );

    gcl_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_token         (q_token),
        .i_q_stat        (q_stat),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_command_class (o_command_class)
    );

    `GCL_ASSERT_NEXT(a_count_push, q_push && !q_pop, q_count == CW'($past(q_count) + 1'b1))
    `GCL_ASSERT_NOW(a_ready_full, !o_ready, q_count == CW'(QUEUE_DEPTH))
    `GCL_ASSERT_NEXT(a_last_gives_class, q_pop && q_token.last, o_valid)

endmodule

[test/tb_gcode_line_classifier.sv]
// ----------------------------------------------------------------------------
// tb_gcode_line_classifier
// Feeds G-code lines, one byte per beat, through the classifier and checks
// every class beat against a scan-state predictor kept in the bench or a pinned
// table class. A short table of hand-picked lines comes first. Random lines
// follow, mostly well-formed commands with noise, broken lines and early zero
// bytes mixed in, under several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_gcode_line_classifier;

    import gcl_pkg::*;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    localparam int BYTES_PER_PHASE = 200;
    localparam int SETTLE_CYCLES   = 16;

    typedef enum logic [2:0] {
        SC_HUNT,
        SC_BLANKS,
        SC_SIGNED,
        SC_NUMBER,
        SC_SETTLED
    } t_scan;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       pinned;
        t_class     cls;
    } t_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_ready;
    logic [7:0] i_line_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       o_valid;
    logic       i_ready     = 1'b0;
    logic [3:0] o_command_class;

    t_scan       scan        = SC_HUNT;
    logic        letter_m    = 1'b0;
    logic        minus_seen  = 1'b0;
    logic [9:0]  number      = '0;
    t_class      settled_cls = CL_NONE;

    t_class      class_q[$];
    t_class      want_cls;
    logic [7:0]  line_buf[$];
    int unsigned mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    int send_idle[4]  = '{0, 70, 0, 38};
    int recv_stall[4] = '{0, 0, 70, 38};
    int known_numbers[17] = '{0, 1, 4, 10, 11, 20, 21, 90, 91,
                              82, 83, 203, 204, 205, 207, 208, 220};
    logic [7:0] lead_chars[6]  = '{CH_SPACE, CH_TAB, "N", "x", "5", "*"};
    logic [7:0] blank_chars[6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    logic [7:0] letters[4]     = '{"G", "g", "M", "m"};

    t_row rows[24] = '{
        '{"G", 1'b0, 1'b0, CL_NONE},      '{"1", 1'b1, 1'b1, CL_MOVE},
        '{"M", 1'b0, 1'b0, CL_NONE},      '{"2", 1'b0, 1'b0, CL_NONE},
        '{"2", 1'b0, 1'b0, CL_NONE},      '{"0", 1'b1, 1'b1, CL_SPEEDOVER},
        '{CH_SEMI, 1'b1, 1'b1, CL_NONE},
        '{8'hFF, 1'b1, 1'b1, CL_NONE},
        '{CH_NUL, 1'b0, 1'b0, CL_NONE},   '{"G", 1'b1, 1'b1, CL_NONE},
        '{"g", 1'b0, 1'b0, CL_NONE},      '{CH_MINUS, 1'b0, 1'b0, CL_NONE},
        '{"5", 1'b1, 1'b1, CL_NONE},
        '{"m", 1'b0, 1'b0, CL_NONE},      '{CH_SPACE, 1'b0, 1'b0, CL_NONE},
        '{"8", 1'b0, 1'b0, CL_NONE},      '{"3", 1'b1, 1'b0, CL_NONE},
        '{"G", 1'b0, 1'b0, CL_NONE},      '{"2", 1'b0, 1'b0, CL_NONE},
        '{"0", 1'b0, 1'b0, CL_NONE},      '{"0", 1'b0, 1'b0, CL_NONE},
        '{"0", 1'b1, 1'b1, CL_NONE},
        '{"G", 1'b0, 1'b0, CL_NONE},      '{CH_MINUS, 1'b1, 1'b0, CL_NONE}
    };

    gcode_line_classifier i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_line_byte     (i_line_byte),
        .i_last_byte     (i_last_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_command_class (o_command_class)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_class lookup_class(input logic is_m, input logic neg,
                                            input logic [9:0] n);
        if (neg && n != 10'd0) return CL_NONE;
        if (is_m) begin
            case (n)
                10'd82:  return CL_EABS;
                10'd83:  return CL_EREL;
                10'd203: return CL_MAXFEED;
                10'd204: return CL_ACCEL;
                10'd205: return CL_JDEV;
                10'd207: return CL_RLEN;
                10'd208: return CL_PLEN;
                10'd220: return CL_SPEEDOVER;
                default: return CL_NONE;
            endcase
        end
        case (n)
            10'd0, 10'd1:   return CL_MOVE;
            10'd4:          return CL_DWELL;
            10'd10, 10'd11: return CL_RETRACT;
            10'd20:         return CL_INCH;
            10'd21:         return CL_MM;
            10'd90:         return CL_ABS;
            10'd91:         return CL_REL;
            default:        return CL_NONE;
        endcase
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    task automatic settle_now();
        settled_cls = lookup_class(letter_m, minus_seen, number);
        scan        = SC_SETTLED;
    endtask

    task automatic take_digit(input logic [7:0] b);
        logic [13:0] grown;
        grown  = 14'(number) * 14'd10 + 14'(b[3:0]);
        number = (grown > 14'd1023) ? 10'd1023 : grown[9:0];
        scan   = SC_NUMBER;
    endtask

    task automatic track_line_byte(input logic [7:0] b, input logic last,
                                   output t_class cls);
        cls = CL_NONE;
        case (scan)
            SC_HUNT: begin
                if (b == CH_NUL || b == CH_SEMI || b == CH_HASH || b == CH_CR ||
                    b == CH_LF) begin
                    settled_cls = CL_NONE;
                    scan        = SC_SETTLED;
                end else if (b == "G" || b == "g") begin
                    letter_m = 1'b0;
                    scan     = SC_BLANKS;
                end else if (b == "M" || b == "m") begin
                    letter_m = 1'b1;
                    scan     = SC_BLANKS;
                end
            end
            SC_BLANKS: begin
                if (b == CH_NUL) begin
                    settle_now();
                end else if (is_blank(b)) begin
                end else if (b == CH_PLUS || b == CH_MINUS) begin
                    minus_seen = (b == CH_MINUS);
                    scan       = SC_SIGNED;
                end else if (is_digit(b)) begin
                    take_digit(b);
                end else begin
                    settle_now();
                end
            end
            SC_SIGNED, SC_NUMBER: begin
                if (is_digit(b)) take_digit(b);
                else settle_now();
            end
            default: scan = SC_SETTLED;
        endcase
        if (last) begin
            if (scan == SC_SETTLED) cls = settled_cls;
            else if (scan == SC_HUNT) cls = CL_NONE;
            else cls = lookup_class(letter_m, minus_seen, number);
            scan        = SC_HUNT;
            letter_m    = 1'b0;
            minus_seen  = 1'b0;
            number      = '0;
            settled_cls = CL_NONE;
        end
    endtask

    task automatic send_beat(input logic [7:0] b, input logic last,
                             input logic pinned, input t_class pinned_cls);
        t_class cls;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_line_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        track_line_byte(b, last, cls);
        if (last) class_q.push_back(pinned ? pinned_cls : cls);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (class_q.size() != 0);
    endtask

    task automatic build_line();
        int    kind;
        int    pick;
        int    value;
        string digits;
        line_buf.delete();
        kind = $urandom_range(99);
        if (kind < 12) begin
            repeat ($urandom_range(5, 1)) line_buf.push_back(8'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(2)) line_buf.push_back(lead_chars[$urandom_range(5)]);
        line_buf.push_back(letters[$urandom_range(3)]);
        repeat ($urandom_range(2)) line_buf.push_back(blank_chars[$urandom_range(5)]);
        pick = $urandom_range(5);
        if (pick == 0) line_buf.push_back(CH_PLUS);
        else if (pick == 1) line_buf.push_back(CH_MINUS);
        pick = $urandom_range(9);
        if (pick < 6) value = known_numbers[$urandom_range(16)];
        else if (pick < 8) value = $urandom_range(999);
        else if (pick == 8) value = $urandom_range(99999, 1000);
        else value = -1;
        if (value >= 0) begin
            digits = $sformatf("%0d", value);
            if ($urandom_range(3) == 0) digits = {"0", digits};
            for (int k = 0; k < digits.len(); k++) line_buf.push_back(digits[k]);
        end
        repeat ($urandom_range(3)) line_buf.push_back(8'($urandom_range(255)));
        if (kind < 24) line_buf[$urandom_range(line_buf.size() - 1)] = CH_NUL;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (class_q.size() == 0) begin
                $error("command_class: no beat expected, actual %0d", o_command_class);
                mismatch_count++;
            end else begin
                want_cls = class_q.pop_front();
                if (o_command_class !== want_cls) begin
                    $error("command_class: expected %0d, actual %0d",
                           want_cls, o_command_class);
                    mismatch_count++;
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        int sent;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[r]) send_beat(rows[r].ch, rows[r].last, rows[r].pinned, rows[r].cls);
        drain_results();
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_idle[p];
            recv_stall_pct = recv_stall[p];
            sent = 0;
            while (sent < BYTES_PER_PHASE) begin
                build_line();
                foreach (line_buf[k])
                    send_beat(line_buf[k], k == line_buf.size() - 1, 1'b0, CL_NONE);
                sent += line_buf.size();
            end
            drain_results();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(8 * 400000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
